FILE: rtl/core/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 16;
   // digit accumulation: count * 10 + 9 needs four more bits than the count
   localparam int unsigned ACC_W    = COUNT_W + 4;

   localparam logic [ACC_W-1:0]  MAX_RECORD = ACC_W'(65535);
   localparam logic [BYTE_W-1:0] SEPARATOR  = 8'h3B;
   localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;

   // bit positions of the flags in rsp_tuser
   localparam int unsigned FLAG_EMPTY = 0;
   localparam int unsigned FLAG_ERROR = 1;
   localparam int unsigned FLAG_W     = 2;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ACC_W-1:0]   acc_type;

   typedef struct packed {
      byte_type out_byte;
      logic     last_of_record;
      logic     empty_record;
      logic     format_error;
   } result_type;

endpackage

FILE: rtl/core/length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream framed as "<decimal length>;<payload>" into records.
//
// req channel: one byte of the framed stream per request.
// rsp channel: one payload byte per request in the payload phase, with tlast
// on the final byte of a record; tuser flags an empty record or a format
// error (bad or missing length, length above 65535). Length digits and a
// separator that opens a payload give no response.
// A request passes an input register and then a result register before its
// response is valid. One request is taken every cycle while the receiver
// keeps up; the limit is the update of the length/countdown register.
// Reset clears both registers and returns the parser to the length phase.
// When the receiver stalls, the result register holds its response; the
// held request waits in the input register, and req_tready drops once both
// are full, so nothing is lost.
// ----------------------------------------------------------------------------
module length_prefix_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last_of_record
   output logic [1:0]  rsp_tuser    // [0] empty_record, [1] format_error
);

   logic                hold_valid;
   lpd_pkg::byte_type   hold_byte;
   logic                advance;
   logic                res_valid;
   lpd_pkg::result_type res;

   // the held request moves on when the result register is free or draining
   assign advance = hold_valid && (!rsp_tvalid || rsp_tready);

   lpd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   lpd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_byte   (hold_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   lpd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .res_valid  (res_valid),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/core/lpd_in_reg.sv
// ----------------------------------------------------------------------------
// lpd_in_reg
// Input register: captures one request byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module lpd_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lpd_pkg::byte_type  req_tdata,   // [7:0] in_byte
   input  logic               advance,
   output logic               hold_valid,
   output lpd_pkg::byte_type  hold_byte
);

   logic              valid_ff;
   logic              valid_in;
   lpd_pkg::byte_type byte_ff;
   logic              load;

   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_tdata;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

FILE: rtl/core/lpd_parse.sv
// ----------------------------------------------------------------------------
// lpd_parse
// Framing state and per-byte decision: length digits, separator, payload
// countdown, error and empty-record results.
// ----------------------------------------------------------------------------
module lpd_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  lpd_pkg::byte_type   in_byte,
   output logic                res_valid,
   output lpd_pkg::result_type res
);

   logic               in_payload_ff, in_payload_in;
   logic               digit_seen_ff, digit_seen_in;
   lpd_pkg::count_type count_ff, count_in;

   lpd_pkg::acc_type   acc_next;
   lpd_pkg::count_type count_dec;
   logic               is_digit;

   assign is_digit = (in_byte >= lpd_pkg::DIGIT_ZERO) && (in_byte <= lpd_pkg::DIGIT_NINE);

   // count * 10 as (count << 3) + (count << 1)
   assign acc_next = {1'b0, count_ff, 3'b000} + {3'b000, count_ff, 1'b0}
                   + lpd_pkg::acc_type'(in_byte - lpd_pkg::DIGIT_ZERO);

   assign count_dec = (count_ff == '0) ? '0 : count_ff - lpd_pkg::COUNT_W'(1);

   always_comb begin
      in_payload_in      = in_payload_ff;
      digit_seen_in      = digit_seen_ff;
      count_in           = count_ff;
      res_valid          = 1'b0;
      res.out_byte       = '0;
      res.last_of_record = 1'b0;
      res.empty_record   = 1'b0;
      res.format_error   = 1'b0;

      if (in_payload_ff) begin
         res_valid    = 1'b1;
         res.out_byte = in_byte;
         count_in     = count_dec;
         if (count_dec == '0) begin
            res.last_of_record = 1'b1;
            in_payload_in      = 1'b0;
            digit_seen_in      = 1'b0;
         end
      end else if (is_digit) begin
         if (acc_next > lpd_pkg::MAX_RECORD) begin
            res_valid        = 1'b1;
            res.format_error = 1'b1;
            digit_seen_in    = 1'b0;
            count_in         = '0;
         end else begin
            digit_seen_in = 1'b1;
            count_in      = acc_next[lpd_pkg::COUNT_W-1:0];
         end
      end else if ((in_byte == lpd_pkg::SEPARATOR) && digit_seen_ff) begin
         digit_seen_in = 1'b0;
         if (count_ff == '0) begin
            res_valid        = 1'b1;
            res.empty_record = 1'b1;
         end else begin
            in_payload_in = 1'b1;
         end
      end else begin
         // stray byte or separator without digits
         res_valid        = 1'b1;
         res.format_error = 1'b1;
         digit_seen_in    = 1'b0;
         count_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         digit_seen_ff <= 1'b0;
         count_ff      <= '0;
      end else if (advance) begin
         in_payload_ff <= in_payload_in;
         digit_seen_ff <= digit_seen_in;
         count_ff      <= count_in;
      end
   end

endmodule

FILE: rtl/core/lpd_out_reg.sv
// ----------------------------------------------------------------------------
// lpd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module lpd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                res_valid,
   input  lpd_pkg::result_type res,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output lpd_pkg::byte_type   rsp_tdata,
   output logic                rsp_tlast,
   output logic [lpd_pkg::FLAG_W-1:0] rsp_tuser
);

   logic                valid_ff, valid_in;
   lpd_pkg::result_type res_ff;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (advance) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.out_byte;
   assign rsp_tlast  = res_ff.last_of_record;
   assign rsp_tuser[lpd_pkg::FLAG_EMPTY] = res_ff.empty_record;
   assign rsp_tuser[lpd_pkg::FLAG_ERROR] = res_ff.format_error;

endmodule
